### rtl/mblu_pkg.sv
// ----------------------------------------------------------------------------
// mblu_pkg - shared types and constants for the bilinear map lookup unit
// Beat layouts, operation codes, register indexes, state encoding and the
// widths of the serial arithmetic datapath.
// ----------------------------------------------------------------------------
package mblu_pkg;

	// map geometry and value format
	localparam int X_POINTS   = 16;
	localparam int Y_POINTS   = 16;
	localparam int VALUE_W    = 16;
	localparam int IDX_W      = 4;
	localparam int PTS_W      = 5;
	localparam int FRAC_SHIFT = 12;
	localparam int FRAC_ONE   = 4096;
	localparam int FRAC_HALF  = 2048;

	// serial arithmetic widths
	localparam int ACC_W      = 28;                    // interpolated value and learn difference
	localparam int MUL_A_W    = 44;                    // wide operand of the multiplier
	localparam int MUL_B_W    = 17;                    // serial operand (fractions, weights)
	localparam int DIV_Q_W    = VALUE_W + FRAC_SHIFT;  // quotient bits before saturation

	typedef enum logic [2:0] {
		KIND_WR_X,
		KIND_WR_Y,
		KIND_WR_CELL,
		KIND_BILIN,
		KIND_CLAMPED,
		KIND_NEAREST,
		KIND_LEARN_BILIN,
		KIND_LEARN_NEAR
	} kind_t;

	typedef enum logic [1:0] {
		CFG_X_POINTS,
		CFG_Y_POINTS,
		CFG_LEARN_LOW,
		CFG_LEARN_HIGH
	} cfg_idx_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [VALUE_W-1:0] x_value;
		logic signed [VALUE_W-1:0] y_value;
		logic [IDX_W-1:0]          col;
		logic [IDX_W-1:0]          row;
		logic signed [VALUE_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] result;
		logic                      saturated;
		logic [IDX_W-1:0]          x_index;
		logic [IDX_W-1:0]          y_index;
	} rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_BR,
		S_CHK1,
		S_CHKN2,
		S_MID,
		S_CHKMID,
		S_RDLO,
		S_RDHI,
		S_FRAC,
		S_DIV,
		S_OP,
		S_NEAR,
		S_CRD,
		S_CCAP,
		S_MUL_GO,
		S_MUL_WAIT,
		S_FINISH
	} state_t;

endpackage

### rtl/mblu_mul.sv
// ----------------------------------------------------------------------------
// mblu_mul - bit-serial signed multiplier
// Shift-add over the bits of operand b, one bit a cycle, least significant
// first; the sign bit of b subtracts.
// ----------------------------------------------------------------------------
module mblu_mul #(
	parameter int A_W = mblu_pkg::MUL_A_W,
	parameter int B_W = mblu_pkg::MUL_B_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [A_W-1:0]   a,
	input  logic signed [B_W-1:0]   b,
	output logic                    done,
	output logic signed [A_W+B_W-1:0] p
);

	localparam int CNT_W = $clog2(B_W);

	logic signed [A_W:0]   h_q;
	logic [B_W-1:0]        l_q;
	logic signed [A_W-1:0] a_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic                  last;
	logic signed [A_W+1:0] a_ext;
	logic signed [A_W+1:0] addend;
	logic signed [A_W+1:0] sum;

	// partial product for the current bit of b
	always_comb begin
		last  = (cnt_q == CNT_W'(B_W - 1));
		a_ext = {{2{a_q[A_W-1]}}, a_q};
		if (l_q[0]) begin
			addend = last ? -a_ext : a_ext;
		end else begin
			addend = '0;
		end
		sum = {h_q[A_W], h_q} + addend;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulator and multiplier shift register
	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= '0;
			l_q <= b;
			a_q <= a;
		end else if (run_q) begin
			h_q <= sum[A_W+1:1];
			l_q <= {sum[0], l_q[B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = {h_q[A_W-1:0], l_q};

endmodule

### rtl/mblu_div.sv
// ----------------------------------------------------------------------------
// mblu_div - serial fraction divider
// Restoring division of (num * 4096) by den, one quotient bit a cycle,
// truncated toward zero and saturated to the signed value range.
// ----------------------------------------------------------------------------
module mblu_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [mblu_pkg::VALUE_W:0]    num,
	input  logic signed [mblu_pkg::VALUE_W:0]    den,
	output logic                                 done,
	output logic signed [mblu_pkg::VALUE_W-1:0]  quot
);

	import mblu_pkg::*;

	localparam int CNT_W = $clog2(DIV_Q_W);
	localparam logic [DIV_Q_W-1:0] MAG_POS = DIV_Q_W'(2 ** (VALUE_W - 1) - 1);
	localparam logic [DIV_Q_W-1:0] MAG_NEG = DIV_Q_W'(2 ** (VALUE_W - 1));

	logic [DIV_Q_W-1:0] dvd_q;
	logic [VALUE_W-1:0] rem_q;
	logic [VALUE_W-1:0] dm_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;
	logic [VALUE_W:0]   num_mag;
	logic [VALUE_W:0]   den_mag;
	logic [VALUE_W:0]   trial;
	logic [VALUE_W:0]   trial_sub;
	logic               fits;
	logic               last;
	logic [DIV_Q_W-1:0] neg_full;

	// magnitudes and one restoring step
	always_comb begin
		num_mag   = num[VALUE_W] ? -num : num;
		den_mag   = den[VALUE_W] ? -den : den;
		trial     = {rem_q, dvd_q[DIV_Q_W-1]};
		trial_sub = trial - {1'b0, dm_q};
		fits      = (trial >= {1'b0, dm_q});
		last      = (cnt_q == CNT_W'(DIV_Q_W - 1));
		neg_full  = -dvd_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend / quotient shift register and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num_mag[VALUE_W-1:0], {FRAC_SHIFT{1'b0}}};
			rem_q <= '0;
			dm_q  <= den_mag[VALUE_W-1:0];
			neg_q <= num[VALUE_W] ^ den[VALUE_W];
		end else if (run_q) begin
			rem_q <= fits ? trial_sub[VALUE_W-1:0] : trial[VALUE_W-1:0];
			dvd_q <= {dvd_q[DIV_Q_W-2:0], fits};
		end
	end

	// sign and saturation
	always_comb begin
		if (neg_q) begin
			if (dvd_q > MAG_NEG) begin
				quot = {1'b1, {(VALUE_W-1){1'b0}}};
			end else begin
				quot = neg_full[VALUE_W-1:0];
			end
		end else begin
			if (dvd_q > MAG_POS) begin
				quot = {1'b0, {(VALUE_W-1){1'b1}}};
			end else begin
				quot = dvd_q[VALUE_W-1:0];
			end
		end
	end

	assign done = done_q;

endmodule

### rtl/map_bilinear_lookup_learn_unit.sv
// ----------------------------------------------------------------------------
// map_bilinear_lookup_learn_unit - 2D map lookup with bilinear learning
// One operation at a time; each request beat returns exactly one response
// beat. The next request is taken while a response still waits.
// ----------------------------------------------------------------------------
// A request beat writes an axis entry or a map cell, or reads or learns at
// an operating point. Reads and learns first bracket each axis (edge
// checks, then a binary search with one registered axis read per step) and
// form each fraction in a bit-serial divider, unless the two bracketing
// entries are equal. Bilinear operations then read four corners and pass
// three products through a bit-serial multiplier; a bilinear learn adds six
// more. Axes and map have no reset: every entry must be written before an
// operation reads it.
// Configuration writes are taken in any cycle and must only be issued while
// the unit is idle.
// ----------------------------------------------------------------------------
module map_bilinear_lookup_learn_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  mblu_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output mblu_pkg::rsp_t                   rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  mblu_pkg::cfg_idx_t               cfg_index,
	input  logic [mblu_pkg::VALUE_W-1:0]     cfg_data
);

	import mblu_pkg::*;

	localparam int P_W    = MUL_A_W + MUL_B_W;
	localparam int CELL_W = 40;
	localparam int ADDR_W = 2 * IDX_W;
	localparam logic [2:0] MS_R0     = 3'd0;
	localparam logic [2:0] MS_R1     = 3'd1;
	localparam logic [2:0] MS_VAL    = 3'd2;
	localparam logic [2:0] MS_DW0    = 3'd3;
	localparam logic [2:0] MS_DW1    = 3'd4;
	localparam logic [2:0] MS_CORNER = 3'd5;
	localparam logic signed [ACC_W-1:0] RES_MAX = ACC_W'(2 ** (VALUE_W - 1) - 1);
	localparam logic signed [ACC_W-1:0] RES_MIN = ~RES_MAX;
	localparam logic signed [VALUE_W-1:0] FRAC_ONE_V  = VALUE_W'(FRAC_ONE);
	localparam logic signed [VALUE_W-1:0] FRAC_HALF_V = VALUE_W'(FRAC_HALF);

	// points in use: zero acts as one, large values stop at the axis length
	function automatic logic [PTS_W-1:0] pts_sat(input logic [PTS_W-1:0] v,
			input logic [PTS_W-1:0] max);
		logic [PTS_W-1:0] r;
		if (v == '0) begin
			r = PTS_W'(1);
		end else if (v > max) begin
			r = max;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// learned cells: upper limit checked first
	function automatic logic signed [VALUE_W-1:0] clamp_learn(
			input logic signed [CELL_W-1:0] v,
			input logic signed [VALUE_W-1:0] lo,
			input logic signed [VALUE_W-1:0] hi);
		logic signed [VALUE_W-1:0] r;
		if (v > CELL_W'(hi)) begin
			r = hi;
		end else if (v < CELL_W'(lo)) begin
			r = lo;
		end else begin
			r = v[VALUE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [VALUE_W-1:0] clamp_frac(
			input logic signed [VALUE_W-1:0] f);
		logic signed [VALUE_W-1:0] r;
		if (f < 0) begin
			r = '0;
		end else if (f > FRAC_ONE_V) begin
			r = FRAC_ONE_V;
		end else begin
			r = f;
		end
		return r;
	endfunction

	state_t state_q, state_d;

	// configuration
	logic [PTS_W-1:0]          xpu_q, ypu_q;
	logic signed [VALUE_W-1:0] llow_q, lhigh_q;

	// current item
	kind_t                     kind_q;
	logic signed [VALUE_W-1:0] xv_q, yv_q, val_q;
	logic [PTS_W-1:0]          nx_q, ny_q;

	// bracket search
	logic                      axis_q;
	logic [IDX_W-1:0]          lo_q, hi_q, mid_q;
	logic signed [VALUE_W-1:0] alo_q;
	logic [IDX_W-1:0]          x_lo_q, x_hi_q, y_lo_q, y_hi_q;
	logic signed [VALUE_W-1:0] fx_q, fy_q;

	// interpolation and learning
	logic signed [VALUE_W-1:0] corner_q [4];
	logic [1:0]                cnt_q;
	logic [2:0]                msel_q;
	logic signed [ACC_W-1:0]   r0_q, r1_q, diff_q, res_q;
	logic signed [MUL_A_W-1:0] dw0_q, dw1_q;

	// response
	rsp_t                      rsp_q;
	logic                      rsp_valid_q;

	// storage
	logic signed [VALUE_W-1:0] x_axis_mem [X_POINTS];
	logic signed [VALUE_W-1:0] y_axis_mem [Y_POINTS];
	logic signed [VALUE_W-1:0] map_mem [X_POINTS * Y_POINTS];
	logic signed [VALUE_W-1:0] ax_rd_q, map_rd_q;

	// combinational
	logic                      accept;
	logic                      is_write;
	logic [PTS_W-1:0]          n_cur, n_m1, n_m2, mid_sum;
	logic signed [VALUE_W-1:0] v_cur;
	logic                      le_rd, ge_rd, lt_rd, span_gt1, frac_eq;
	logic [IDX_W-1:0]          ax_addr;
	logic signed [VALUE_W:0]   div_num, div_den;
	logic signed [VALUE_W-1:0] div_q;
	logic                      div_start, div_done;
	logic                      commit;
	logic signed [VALUE_W-1:0] frac_new;
	logic [ADDR_W-1:0]         near_addr, cor_addr, map_raddr;
	logic                      map_we;
	logic [ADDR_W-1:0]         map_wa;
	logic signed [VALUE_W-1:0] map_wd;
	logic signed [VALUE_W:0]   wx_lo, wy_lo, fx_ext, fy_ext;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic                      mul_start, mul_done;
	logic signed [P_W-1:0]     mul_p, p12, p24;
	logic signed [ACC_W-1:0]   lerp_base, lerp_out, diff_new;
	logic signed [CELL_W-1:0]  new_cell;
	logic                      out_free;

	mblu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_q)
	);

	mblu_mul #(
		.A_W (MUL_A_W),
		.B_W (MUL_B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// bracket search helpers
	always_comb begin
		n_cur    = axis_q ? ny_q : nx_q;
		v_cur    = axis_q ? yv_q : xv_q;
		n_m1     = n_cur - PTS_W'(1);
		n_m2     = n_cur - PTS_W'(2);
		mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
		le_rd    = (v_cur <= ax_rd_q);
		ge_rd    = (v_cur >= ax_rd_q);
		lt_rd    = (v_cur < ax_rd_q);
		span_gt1 = ((hi_q - lo_q) > IDX_W'(1));
		frac_eq  = (ax_rd_q == alo_q);
		div_num  = {v_cur[VALUE_W-1], v_cur} - {alo_q[VALUE_W-1], alo_q};
		div_den  = {ax_rd_q[VALUE_W-1], ax_rd_q} - {alo_q[VALUE_W-1], alo_q};
		commit   = ((state_q == S_FRAC) && frac_eq) || ((state_q == S_DIV) && div_done);
		frac_new = (state_q == S_FRAC) ? FRAC_ONE_V : div_q;
	end

	// axis read address
	always_comb begin
		unique case (state_q)
			S_BR:    ax_addr = IDX_W'(1);
			S_CHK1:  ax_addr = n_m2[IDX_W-1:0];
			S_MID:   ax_addr = mid_sum[IDX_W:1];
			S_RDLO:  ax_addr = lo_q;
			S_RDHI:  ax_addr = hi_q;
			default: ax_addr = '0;
		endcase
	end

	// map addressing
	always_comb begin
		near_addr = {(fy_q >= FRAC_HALF_V) ? y_hi_q : y_lo_q,
		             (fx_q >= FRAC_HALF_V) ? x_hi_q : x_lo_q};
		cor_addr  = {cnt_q[1] ? y_hi_q : y_lo_q, cnt_q[0] ? x_hi_q : x_lo_q};
		map_raddr = (state_q == S_OP) ? near_addr : cor_addr;
	end

	// multiplier operands
	always_comb begin
		fx_ext = {fx_q[VALUE_W-1], fx_q};
		fy_ext = {fy_q[VALUE_W-1], fy_q};
		wx_lo  = (VALUE_W+1)'(FRAC_ONE) - fx_ext;
		wy_lo  = (VALUE_W+1)'(FRAC_ONE) - fy_ext;
		case (msel_q)
			MS_R0: begin
				mul_a = MUL_A_W'(corner_q[1]) - MUL_A_W'(corner_q[0]);
				mul_b = MUL_B_W'(fx_ext);
			end
			MS_R1: begin
				mul_a = MUL_A_W'(corner_q[3]) - MUL_A_W'(corner_q[2]);
				mul_b = MUL_B_W'(fx_ext);
			end
			MS_VAL: begin
				mul_a = MUL_A_W'(r1_q) - MUL_A_W'(r0_q);
				mul_b = MUL_B_W'(fy_ext);
			end
			MS_DW0: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(wx_lo);
			end
			MS_DW1: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'(fx_ext);
			end
			default: begin
				mul_a = cnt_q[0] ? dw1_q : dw0_q;
				mul_b = cnt_q[1] ? MUL_B_W'(fy_ext) : MUL_B_W'(wy_lo);
			end
		endcase
	end

	// rounding of products and corner update
	always_comb begin
		p12 = (mul_p + P_W'(FRAC_HALF)) >>> FRAC_SHIFT;
		p24 = (mul_p + (P_W'(1) <<< (2 * FRAC_SHIFT - 1))) >>> (2 * FRAC_SHIFT);
		case (msel_q)
			MS_R0:   lerp_base = ACC_W'(corner_q[0]);
			MS_R1:   lerp_base = ACC_W'(corner_q[2]);
			default: lerp_base = r0_q;
		endcase
		lerp_out = lerp_base + p12[ACC_W-1:0];
		diff_new = ACC_W'(val_q) - lerp_out;
		new_cell = CELL_W'(corner_q[cnt_q]) + p24[CELL_W-1:0];
	end

	// map write port
	always_comb begin
		map_we = 1'b0;
		map_wa = cor_addr;
		map_wd = clamp_learn(new_cell, llow_q, lhigh_q);
		if (accept && (req.kind == KIND_WR_CELL)) begin
			map_we = 1'b1;
			map_wa = {req.row, req.col};
			map_wd = req.value_in;
		end else if ((state_q == S_NEAR) && (kind_q == KIND_LEARN_NEAR)) begin
			map_we = 1'b1;
			map_wa = near_addr;
			map_wd = clamp_learn(CELL_W'(val_q), llow_q, lhigh_q);
		end else if ((state_q == S_MUL_WAIT) && mul_done && (msel_q == MS_CORNER)) begin
			map_we = 1'b1;
		end
	end

	// next state and strobes
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		is_write  = 1'b0;
		case (req.kind) inside
			KIND_WR_X, KIND_WR_Y, KIND_WR_CELL: is_write = 1'b1;
			default:                            is_write = 1'b0;
		endcase
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = is_write ? S_FINISH : S_BR;
				end
			end
			S_BR:     state_d = (n_cur == PTS_W'(1)) ? S_RDLO : S_CHK1;
			S_CHK1:   state_d = le_rd ? S_RDLO : S_CHKN2;
			S_CHKN2:  state_d = ge_rd ? S_RDLO : S_MID;
			S_MID:    state_d = span_gt1 ? S_CHKMID : S_RDLO;
			S_CHKMID: state_d = S_MID;
			S_RDLO:   state_d = S_RDHI;
			S_RDHI:   state_d = S_FRAC;
			S_FRAC: begin
				if (frac_eq) begin
					state_d = axis_q ? S_OP : S_BR;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = axis_q ? S_OP : S_BR;
				end
			end
			S_OP: begin
				case (kind_q) inside
					KIND_NEAREST, KIND_LEARN_NEAR: state_d = S_NEAR;
					default:                       state_d = S_CRD;
				endcase
			end
			S_NEAR:   state_d = S_FINISH;
			S_CRD:    state_d = S_CCAP;
			S_CCAP:   state_d = (cnt_q == 2'd3) ? S_MUL_GO : S_CRD;
			S_MUL_GO: begin
				mul_start = 1'b1;
				state_d   = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (mul_done) begin
					if (msel_q == MS_VAL) begin
						state_d = (kind_q == KIND_LEARN_BILIN) ? S_MUL_GO : S_FINISH;
					end else if (msel_q == MS_CORNER) begin
						state_d = (cnt_q == 2'd3) ? S_FINISH : S_MUL_GO;
					end else begin
						state_d = S_MUL_GO;
					end
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cfg_ready = 1'b1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xpu_q   <= PTS_W'(X_POINTS);
			ypu_q   <= PTS_W'(Y_POINTS);
			llow_q  <= {1'b1, {(VALUE_W-1){1'b0}}};
			lhigh_q <= {1'b0, {(VALUE_W-1){1'b1}}};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_X_POINTS:   xpu_q   <= cfg_data[PTS_W-1:0];
				CFG_Y_POINTS:   ypu_q   <= cfg_data[PTS_W-1:0];
				CFG_LEARN_LOW:  llow_q  <= cfg_data;
				CFG_LEARN_HIGH: lhigh_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	// sequencing counters and response handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			msel_q      <= MS_R0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				axis_q <= 1'b0;
			end else if (commit && !axis_q) begin
				axis_q <= 1'b1;
			end

			if (state_q == S_OP) begin
				cnt_q <= '0;
			end else if (state_q == S_CCAP) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					msel_q <= MS_R0;
				end
			end else if ((state_q == S_MUL_WAIT) && mul_done) begin
				if (msel_q == MS_CORNER) begin
					cnt_q <= cnt_q + 2'd1;
				end else begin
					msel_q <= msel_q + 3'd1;
				end
			end

			if ((state_q == S_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			xv_q   <= req.x_value;
			yv_q   <= req.y_value;
			val_q  <= req.value_in;
			nx_q   <= pts_sat(xpu_q, PTS_W'(X_POINTS));
			ny_q   <= pts_sat(ypu_q, PTS_W'(Y_POINTS));
			x_lo_q <= '0;
			y_lo_q <= '0;
			res_q  <= '0;
		end

		// bracket edges and binary search
		unique case (state_q)
			S_BR: begin
				lo_q <= '0;
				hi_q <= '0;
			end
			S_CHK1: begin
				if (le_rd) begin
					lo_q <= '0;
					hi_q <= IDX_W'(1);
				end
			end
			S_CHKN2: begin
				if (ge_rd) begin
					lo_q <= n_m2[IDX_W-1:0];
				end else begin
					lo_q <= '0;
				end
				hi_q <= n_m1[IDX_W-1:0];
			end
			S_MID: mid_q <= mid_sum[IDX_W:1];
			S_CHKMID: begin
				if (lt_rd) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q;
				end
			end
			S_RDHI: alo_q <= ax_rd_q;
			default: ;
		endcase

		if (commit) begin
			if (axis_q) begin
				y_lo_q <= lo_q;
				y_hi_q <= hi_q;
				fy_q   <= frac_new;
			end else begin
				x_lo_q <= lo_q;
				x_hi_q <= hi_q;
				fx_q   <= frac_new;
			end
		end

		if ((state_q == S_OP) && (kind_q == KIND_CLAMPED)) begin
			fx_q <= clamp_frac(fx_q);
			fy_q <= clamp_frac(fy_q);
		end

		if (state_q == S_NEAR) begin
			if (kind_q == KIND_NEAREST) begin
				res_q <= ACC_W'(map_rd_q);
			end else begin
				res_q <= ACC_W'(val_q) - ACC_W'(map_rd_q);
			end
		end

		if (state_q == S_CCAP) begin
			corner_q[cnt_q] <= map_rd_q;
		end

		// products come back from the serial multiplier
		if ((state_q == S_MUL_WAIT) && mul_done) begin
			case (msel_q)
				MS_R0: r0_q <= lerp_out;
				MS_R1: r1_q <= lerp_out;
				MS_VAL: begin
					diff_q <= diff_new;
					res_q  <= (kind_q == KIND_LEARN_BILIN) ? diff_new : lerp_out;
				end
				MS_DW0: dw0_q <= mul_p[MUL_A_W-1:0];
				MS_DW1: dw1_q <= mul_p[MUL_A_W-1:0];
				default: ;
			endcase
		end

		// result beat with saturation
		if ((state_q == S_FINISH) && out_free) begin
			rsp_q.x_index <= x_lo_q;
			rsp_q.y_index <= y_lo_q;
			if (res_q > RES_MAX) begin
				rsp_q.result    <= RES_MAX[VALUE_W-1:0];
				rsp_q.saturated <= 1'b1;
			end else if (res_q < RES_MIN) begin
				rsp_q.result    <= RES_MIN[VALUE_W-1:0];
				rsp_q.saturated <= 1'b1;
			end else begin
				rsp_q.result    <= res_q[VALUE_W-1:0];
				rsp_q.saturated <= 1'b0;
			end
		end
	end

	// axis memories
	always_ff @(posedge clk) begin
		if (accept && (req.kind == KIND_WR_X)) begin
			x_axis_mem[req.col] <= req.value_in;
		end
		if (accept && (req.kind == KIND_WR_Y)) begin
			y_axis_mem[req.col] <= req.value_in;
		end
		ax_rd_q <= axis_q ? y_axis_mem[ax_addr] : x_axis_mem[ax_addr];
	end

	// map memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_wa] <= map_wd;
		end
		map_rd_q <= map_mem[map_raddr];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### bench/mblu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mblu_checker - response predictor and scoreboard for the map lookup unit
// Watches the request, response and register channels. For every accepted
// request beat it computes the expected response from its own copy of the
// axes, map and registers, and compares each response beat field by field.
// ----------------------------------------------------------------------------
module mblu_checker
	import mblu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_ready,
	input  req_t               req,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  rsp_t               rsp,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  cfg_idx_t           cfg_index,
	input  logic [VALUE_W-1:0] cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 checked
);

	// shadow state of the unit
	longint x_pts [X_POINTS];
	longint y_pts [Y_POINTS];
	longint cells [X_POINTS*Y_POINTS];
	int     x_used, y_used;
	longint lim_low, lim_high;
	rsp_t   rsp_queue [$];

	function automatic longint axis_at(input bit on_x, input int i);
		return on_x ? x_pts[i] : y_pts[i];
	endfunction

	function automatic longint rnd12(input longint p);
		return (p + 2048) >>> 12;
	endfunction

	function automatic longint rnd24(input longint p);
		return (p + (64'sd1 <<< 23)) >>> 24;
	endfunction

	function automatic longint clamp_cell(input longint v);
		if (v > lim_high) return lim_high;
		if (v < lim_low) return lim_low;
		return v;
	endfunction

	// bracket search plus signed Q4.12 fraction
	function automatic void locate(input longint v, input bit on_x, input int n,
			output int lo, output int hi, output longint frac);
		int a, b, mid;
		longint q;
		if (n <= 1) begin
			lo = 0; hi = 0;
		end else if (v <= axis_at(on_x, 1)) begin
			lo = 0; hi = 1;
		end else if (v >= axis_at(on_x, n-2)) begin
			lo = n-2; hi = n-1;
		end else begin
			a = 0; b = n-1;
			while (b - a > 1) begin
				mid = (a + b) / 2;
				if (v < axis_at(on_x, mid)) b = mid;
				else a = mid;
			end
			lo = a; hi = a + 1;
		end
		if (axis_at(on_x, hi) == axis_at(on_x, lo)) begin
			frac = FRAC_ONE;
		end else begin
			q = ((v - axis_at(on_x, lo)) * FRAC_ONE) / (axis_at(on_x, hi) - axis_at(on_x, lo));
			if (q > 32767) q = 32767;
			if (q < -32768) q = -32768;
			frac = q;
		end
	endfunction

	function automatic longint interp(input int xl, input int xh, input longint fx,
			input int yl, input int yh, input longint fy);
		longint c00, c01, c10, c11, r0, r1;
		c00 = cells[yl*X_POINTS+xl]; c01 = cells[yl*X_POINTS+xh];
		c10 = cells[yh*X_POINTS+xl]; c11 = cells[yh*X_POINTS+xh];
		r0 = c00 + rnd12((c01 - c00) * fx);
		r1 = c10 + rnd12((c11 - c10) * fx);
		return r0 + rnd12((r1 - r0) * fy);
	endfunction

	// expected response beat; updates the shadow state as the unit would
	function automatic rsp_t predict_response(input req_t r);
		rsp_t   o;
		int     nx, ny, xl, xh, yl, yh, cx, cy, i, j;
		int     xs [2], ys [2];
		longint fx, fy, res, diff, tgt;
		longint wx [2], wy [2];
		longint prev [2][2];
		o = '0;
		tgt = longint'(r.value_in);
		case (r.kind)
			KIND_WR_X:    x_pts[r.col] = tgt;
			KIND_WR_Y:    y_pts[r.col] = tgt;
			KIND_WR_CELL: cells[r.row*X_POINTS + r.col] = tgt;
			default: begin
				nx = (x_used < 1) ? 1 : (x_used > X_POINTS) ? X_POINTS : x_used;
				ny = (y_used < 1) ? 1 : (y_used > Y_POINTS) ? Y_POINTS : y_used;
				locate(longint'(r.x_value), 1'b1, nx, xl, xh, fx);
				locate(longint'(r.y_value), 1'b0, ny, yl, yh, fy);
				o.x_index = xl[IDX_W-1:0];
				o.y_index = yl[IDX_W-1:0];
				if (r.kind == KIND_BILIN) begin
					res = interp(xl, xh, fx, yl, yh, fy);
				end else if (r.kind == KIND_CLAMPED) begin
					fx = (fx < 0) ? 0 : (fx > FRAC_ONE) ? FRAC_ONE : fx;
					fy = (fy < 0) ? 0 : (fy > FRAC_ONE) ? FRAC_ONE : fy;
					res = interp(xl, xh, fx, yl, yh, fy);
				end else if (r.kind == KIND_NEAREST || r.kind == KIND_LEARN_NEAR) begin
					cx = (fx >= FRAC_HALF) ? xh : xl;
					cy = (fy >= FRAC_HALF) ? yh : yl;
					if (r.kind == KIND_NEAREST) begin
						res = cells[cy*X_POINTS+cx];
					end else begin
						res = tgt - cells[cy*X_POINTS+cx];
						cells[cy*X_POINTS+cx] = clamp_cell(tgt);
					end
				end else begin
					// bilinear learn: spread the error by corner weight
					diff = tgt - interp(xl, xh, fx, yl, yh, fy);
					wx[0] = FRAC_ONE - fx; wx[1] = fx;
					wy[0] = FRAC_ONE - fy; wy[1] = fy;
					xs[0] = xl; xs[1] = xh; ys[0] = yl; ys[1] = yh;
					for (i = 0; i < 2; i++)
						for (j = 0; j < 2; j++)
							prev[i][j] = cells[ys[i]*X_POINTS+xs[j]];
					for (i = 0; i < 2; i++)
						for (j = 0; j < 2; j++)
							cells[ys[i]*X_POINTS+xs[j]] =
								prev[i][j] + rnd24(diff * wx[j] * wy[i]);
					for (i = 0; i < 2; i++)
						for (j = 0; j < 2; j++)
							cells[ys[i]*X_POINTS+xs[j]] =
								clamp_cell(cells[ys[i]*X_POINTS+xs[j]]);
					res = diff;
				end
				if (res > 32767) begin
					res = 32767; o.saturated = 1'b1;
				end
				if (res < -32768) begin
					res = -32768; o.saturated = 1'b1;
				end
				o.result = res[VALUE_W-1:0];
			end
		endcase
		return o;
	endfunction

	initial begin
		errors = 0;
		checked = 0;
		pending = 0;
		foreach (x_pts[i]) x_pts[i] = 0;
		foreach (y_pts[i]) y_pts[i] = 0;
		foreach (cells[i]) cells[i] = 0;
	end

	// register writes, request prediction and response comparison
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			x_used   = 16;
			y_used   = 16;
			lim_low  = -32768;
			lim_high = 32767;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_X_POINTS:   x_used = int'(cfg_data[PTS_W-1:0]);
					CFG_Y_POINTS:   y_used = int'(cfg_data[PTS_W-1:0]);
					CFG_LEARN_LOW:  lim_low = longint'($signed(cfg_data));
					CFG_LEARN_HIGH: lim_high = longint'($signed(cfg_data));
				endcase
			end
			if (req_valid && req_ready)
				rsp_queue.push_back(predict_response(req));
			if (rsp_valid && rsp_ready) begin
				if (rsp_queue.size() == 0) begin
					$display("%0t: response beat with nothing expected: %p", $time, rsp);
					errors++;
				end else begin
					e = rsp_queue.pop_front();
					checked++;
					if (rsp.result !== e.result) begin
						$display("%0t: result expected %0d actual %0d", $time,
							e.result, rsp.result);
						errors++;
					end
					if (rsp.saturated !== e.saturated) begin
						$display("%0t: saturated expected %0b actual %0b", $time,
							e.saturated, rsp.saturated);
						errors++;
					end
					if (rsp.x_index !== e.x_index) begin
						$display("%0t: x_index expected %0d actual %0d", $time,
							e.x_index, rsp.x_index);
						errors++;
					end
					if (rsp.y_index !== e.y_index) begin
						$display("%0t: y_index expected %0d actual %0d", $time,
							e.y_index, rsp.y_index);
						errors++;
					end
				end
			end
			pending = rsp_queue.size();
		end
	end

endmodule

### bench/tb_map_bilinear_lookup_learn_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_map_bilinear_lookup_learn_unit - testbench for the map lookup unit
// Loads sorted axes and a full map, runs directed edge cases, then random
// reads, learns and writes over several register settings with bursty
// requests and a stalling receiver. The checker module does the scoring.
// ----------------------------------------------------------------------------
module tb_map_bilinear_lookup_learn_unit;
	import mblu_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	req_t               req = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	rsp_t               rsp;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	cfg_idx_t           cfg_index = CFG_X_POINTS;
	logic [VALUE_W-1:0] cfg_data = '0;

	int errors, pending, checked;
	int sent, burst_left, settings_run;
	int hold_req = 0;
	int x_shadow [X_POINTS];
	int y_shadow [Y_POINTS];
	int x_cur, y_cur;

	always #10 clk = ~clk;

	map_bilinear_lookup_learn_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mblu_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .checked(checked)
	);

	// receiver: random stall pattern from four modes; long hold on request
	initial begin
		int mode, cnt, hold_done;
		mode = 0;
		cnt = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				rsp_ready <= 1'b0;
				repeat (800) @(posedge clk);
			end
			if (cnt % 64 == 0) mode = $urandom_range(0, 3);
			cnt++;
			case (mode)
				0:       rsp_ready <= 1'b1;
				1:       rsp_ready <= ($urandom_range(0, 1) == 0);
				2:       rsp_ready <= ($urandom_range(0, 9) == 0);
				default: rsp_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin
		#50ms;
		$display("run timed out");
		$display("FAIL map_bilinear_lookup_learn_unit");
		$finish;
	end

	function automatic logic signed [VALUE_W-1:0] sat16(input int v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[VALUE_W-1:0];
	endfunction

	// one request beat, bursts and gaps on the sender side
	task automatic send(input req_t r);
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 3) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	endtask

	// let the clock tick first so the last accepted beat is already counted
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [VALUE_W-1:0] d);
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic apply_setting(input int nx, input int ny, input int lo, input int hi);
		drain();
		write_reg(CFG_X_POINTS, nx[VALUE_W-1:0]);
		write_reg(CFG_Y_POINTS, ny[VALUE_W-1:0]);
		write_reg(CFG_LEARN_LOW, lo[VALUE_W-1:0]);
		write_reg(CFG_LEARN_HIGH, hi[VALUE_W-1:0]);
		cfg_valid <= 1'b0;
		x_cur = (nx < 1) ? 1 : (nx > 16) ? 16 : nx;
		y_cur = (ny < 1) ? 1 : (ny > 16) ? 16 : ny;
		settings_run++;
	endtask

	task automatic write_entry(input kind_t k, input int c, input int rw, input int v);
		req_t r;
		r = '0;
		r.kind = k;
		r.col = c[IDX_W-1:0];
		r.row = rw[IDX_W-1:0];
		r.value_in = sat16(v);
		r.x_value = VALUE_W'($urandom);
		r.y_value = VALUE_W'($urandom);
		if (k == KIND_WR_X) x_shadow[c] = int'(r.value_in);
		if (k == KIND_WR_Y) y_shadow[c] = int'(r.value_in);
		send(r);
	endtask

	// ascending axis, occasional repeated breakpoints
	task automatic load_axis(input kind_t k, input int spread);
		int v;
		v = $urandom_range(0, 20000) - 30000;
		for (int i = 0; i < 16; i++) begin
			write_entry(k, i, 0, v);
			v += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, spread);
		end
	endtask

	function automatic int pick_point(input bit on_x);
		int n, a, b, m;
		n = on_x ? x_cur : y_cur;
		a = on_x ? x_shadow[0] : y_shadow[0];
		b = on_x ? x_shadow[n-1] : y_shadow[n-1];
		if (a > b) begin
			m = a; a = b; b = m;
		end
		m = $urandom_range(0, 9);
		if (m < 6)
			return a + int'($urandom_range(0, b - a));
		if (m < 8)
			return (on_x ? x_shadow[$urandom_range(0, n-1)] : y_shadow[$urandom_range(0, n-1)])
				+ $urandom_range(0, 2) - 1;
		return $signed(16'($urandom));
	endfunction

	task automatic operate(input kind_t k, input int xv, input int yv, input int tgt);
		req_t r;
		r = '0;
		r.kind = k;
		r.x_value = sat16(xv);
		r.y_value = sat16(yv);
		r.col = IDX_W'($urandom);
		r.row = IDX_W'($urandom);
		r.value_in = sat16(tgt);
		send(r);
	endtask

	task automatic random_items(input int count);
		int m;
		for (int i = 0; i < count; i++) begin
			m = $urandom_range(0, 19);
			if (m < 3)
				write_entry(KIND_WR_CELL, $urandom_range(0, 15), $urandom_range(0, 15),
					($urandom_range(0, 1) != 0) ? $signed(16'($urandom))
						: $urandom_range(0, 2000) - 1000);
			else if (m == 3)
				write_entry(($urandom_range(0, 1) != 0) ? KIND_WR_X : KIND_WR_Y,
					$urandom_range(0, 15), 0, $signed(16'($urandom)));
			else
				operate(kind_t'($urandom_range(3, 7)), pick_point(1'b1), pick_point(1'b0),
					($urandom_range(0, 2) == 0) ? $signed(16'($urandom))
						: $urandom_range(0, 4000) - 2000);
		end
	endtask

	initial begin
		sent = 0;
		burst_left = 0;
		settings_run = 0;
		x_cur = 16;
		y_cur = 16;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill axes and the whole map before anything reads them
		load_axis(KIND_WR_X, 3000);
		load_axis(KIND_WR_Y, 3000);
		for (int rw = 0; rw < 16; rw++)
			for (int c = 0; c < 16; c++)
				write_entry(KIND_WR_CELL, c, rw, $signed(16'($urandom)));
		apply_setting(16, 16, -32768, 32767);

		// directed: field extremes, exact breakpoints, midpoints, every operation
		for (int k = 3; k <= 7; k++) begin
			operate(kind_t'(k), -32768, 32767, 32767);
			operate(kind_t'(k), 32767, -32768, -32768);
			operate(kind_t'(k), x_shadow[5], y_shadow[9], 0);
			operate(kind_t'(k), (x_shadow[7] + x_shadow[8]) / 2,
				(y_shadow[2] + y_shadow[3]) / 2, 1234);
		end
		// repeated breakpoint at x entries 7 and 8, read exactly on it
		write_entry(KIND_WR_X, 8, 0, x_shadow[7]);
		operate(KIND_BILIN, x_shadow[7], y_shadow[4], 0);
		operate(KIND_LEARN_BILIN, x_shadow[7], y_shadow[4], -5000);

		// random phases over register settings, extremes included
		random_items(200);
		hold_req++;                         // receiver holds off, unit fills up
		random_items(120);
		apply_setting(1, 1, -32768, 32767);
		random_items(100);
		apply_setting(0, 31, -200, 200);
		random_items(120);
		apply_setting(2, 3, 1000, -1000);   // crossed limits
		random_items(120);
		apply_setting(16, 7, -32768, -32768);
		load_axis(KIND_WR_X, 200);
		random_items(150);
		apply_setting(9, 16, 32767, 32767);
		load_axis(KIND_WR_Y, 4000);
		random_items(150);
		apply_setting(16, 16, -32768, 32767);
		random_items(200);

		drain();
		repeat (300) @(posedge clk);
		$display("Sent %0d request beats over %0d register settings, %0d responses checked.",
			sent, settings_run, checked);
		if (errors == 0 && pending == 0)
			$display("PASS map_bilinear_lookup_learn_unit");
		else
			$display("FAIL map_bilinear_lookup_learn_unit");
		$finish;
	end

endmodule

### sim.f
rtl/mblu_pkg.sv
rtl/mblu_mul.sv
rtl/mblu_div.sv
rtl/map_bilinear_lookup_learn_unit.sv
bench/mblu_checker.sv
bench/tb_map_bilinear_lookup_learn_unit.sv
